@@ src/assert_macros.svh @@
// Assertion macros used by the port checker of the bitmap allocator.
// Each macro takes a label, the clock, the active-low reset, a condition and a consequence.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequence must hold in the same cycle as the condition.
`define BAM_ASSERT_SAME(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("bitmap allocator check failed");

// The consequence must hold in the cycle after the condition.
`define BAM_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("bitmap allocator check failed");

`endif

@@ src/bam_pkg.sv @@
// Package of the bitmap allocator: command and status codes, field widths, defaults.
// It depends on nothing else; the top level and the checker use it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package bam_pkg;

  // Default geometry of the bit store.
  localparam int MAX_BITS_DEF  = 1024;
  localparam int WORD_BITS_DEF = 32;

  // Widths of the stream fields.
  localparam int CMD_W    = 3;
  localparam int IDX_W    = 10;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 11;
  localparam int CFG_W    = 11;

  // Register index of bits_in_use.
  localparam logic [0:0] REG_BITS_IN_USE = 1'b0;

  typedef enum logic [CMD_W-1:0] {
    CMD_MARK       = 3'd0,
    CMD_CLEAR      = 3'd1,
    CMD_FLIP       = 3'd2,
    CMD_TEST       = 3'd3,
    CMD_FIND_SET   = 3'd4,
    CMD_FIND_CLEAR = 3'd5,
    CMD_SET_ALL    = 3'd6,
    CMD_CLEAR_ALL  = 3'd7
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_NONE  = 2'd2
  } status_t;

endpackage

`default_nettype wire

@@ src/bam_ram.sv @@
// Generic single-write, single-read synchronous RAM with a registered read port.
// It depends on nothing else; the bitmap allocator keeps its bit words in it.
`timescale 1ns / 1ps
`default_nettype none

module bam_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ src/bitmap_allocator_unit.sv @@
// Top level of the bitmap allocator: bit store in a RAM, request sequencer, config register.
// It depends on bam_pkg and bam_ram.
//
//  Channel   Direction  Signals                              Transaction
//  in_       slave      in_tvalid, in_tready, in_tdata       one request
//  out_      master     out_tvalid, out_tready, out_tdata    one result per request
//  cfg_      APB slave  psel, penable, pwrite, paddr, pwdata write or read bits_in_use
//
// A mark, clear, flip or test goes through accept and RAM read, modify and write back,
// and result once the output register is free. An out-of-range index skips the RAM.
// A find reads one RAM word per cycle until a hit or the last word; set all and clear all
// sweep the RAM. After reset and after every write of bits_in_use a clearing pass over
// every word runs with in_tready low. Reset is synchronous and active low.
// A new request is accepted while the previous result still waits on out_tready.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_allocator_unit #(
  parameter int MAX_BITS  = bam_pkg::MAX_BITS_DEF,
  parameter int WORD_BITS = bam_pkg::WORD_BITS_DEF  // power of two
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata: cmd [2:0], bit_index [12:3], zero [15:13]
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,
  // out_tdata: bit_value [0], found_index [10:1], status [12:11], set_count [23:13],
  // any_set [24], all_set [25], zero [31:26]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int SH        = $clog2(WORD_BITS);
  localparam int NUM_WORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int CNT_W     = $clog2(MAX_BITS + 1);
  localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(NUM_WORDS - 1);

  typedef enum logic [2:0] {
    S_FILL,
    S_IDLE,
    S_MOD,
    S_SCAN,
    S_DONE
  } state_t;

  // Control registers.
  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [WADDR_W-1:0] wcnt_r, wcnt_nxt;
  logic               fill_set_r, fill_set_nxt;
  logic               report_r, report_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Payload registers.
  bam_pkg::cmd_t             cmd_r, cmd_nxt;
  logic [SH-1:0]             pos_r, pos_nxt;
  logic [WADDR_W-1:0]        waddr_r, waddr_nxt;
  logic                      res_bit_r, res_bit_nxt;
  logic [bam_pkg::IDX_W-1:0] res_found_r, res_found_nxt;
  bam_pkg::status_t          res_status_r, res_status_nxt;
  logic [31:0]               out_data_r, out_data_nxt;

  // RAM ports.
  logic                 ram_we;
  logic [WADDR_W-1:0]   ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WADDR_W-1:0]   ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  bam_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(NUM_WORDS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Request fields.
  bam_pkg::cmd_t             in_cmd;
  logic [bam_pkg::IDX_W-1:0] in_idx;
  logic [31:0]               idx_ext;
  logic                      in_range;

  assign in_cmd   = bam_pkg::cmd_t'(in_tdata[2:0]);
  assign in_idx   = in_tdata[12:3];
  assign idx_ext  = 32'(in_idx);
  assign in_range = idx_ext < 32'(n_r);

  // Configuration port.
  logic                      cfg_wr;
  logic [bam_pkg::CFG_W-1:0] cfg_val;
  logic [CNT_W-1:0]          cfg_sat;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr[2] == bam_pkg::REG_BITS_IN_USE);
  assign cfg_val    = cfg_pwdata[bam_pkg::CFG_W-1:0];
  assign cfg_sat    = (32'(cfg_val) > 32'(MAX_BITS)) ? CNT_W'(MAX_BITS) : CNT_W'(cfg_val);
  assign cfg_prdata = (cfg_paddr[2] == bam_pkg::REG_BITS_IN_USE) ? 32'(n_r) : 32'd0;

  // Mask of the in-use bits of the word at wcnt_r.
  logic [31:0]          mask_base;
  logic [31:0]          mask_diff;
  logic [WORD_BITS-1:0] word_mask;

  assign mask_base = 32'(wcnt_r) << SH;
  assign mask_diff = 32'(n_r) - mask_base;

  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      word_mask[j] = (mask_base < 32'(n_r)) && (32'(j) < mask_diff);
    end
  end

  // Lowest in-use bit of the asked polarity in the word being scanned.
  logic [WORD_BITS-1:0] cand;
  logic                 hit;
  logic [SH-1:0]        hit_pos;

  assign cand = ((cmd_r == bam_pkg::CMD_FIND_CLEAR) ? ram_rdata : ~ram_rdata) & word_mask;
  assign hit  = |cand;

  always_comb begin
    hit_pos = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (cand[j]) begin
        hit_pos = SH'(j);
      end
    end
  end

  // Single-bit update of the addressed word.
  logic                 old_bit;
  logic                 new_bit;
  logic [WORD_BITS-1:0] mod_word;

  assign old_bit = ram_rdata[pos_r];

  always_comb begin
    case (cmd_r)
      bam_pkg::CMD_MARK:  new_bit = 1'b1;
      bam_pkg::CMD_CLEAR: new_bit = 1'b0;
      bam_pkg::CMD_FLIP:  new_bit = ~old_bit;
      default:            new_bit = old_bit;
    endcase
    mod_word        = ram_rdata;
    mod_word[pos_r] = new_bit;
  end

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    n_nxt          = n_r;
    cnt_nxt        = cnt_r;
    wcnt_nxt       = wcnt_r;
    fill_set_nxt   = fill_set_r;
    report_nxt     = report_r;
    cmd_nxt        = cmd_r;
    pos_nxt        = pos_r;
    waddr_nxt      = waddr_r;
    res_bit_nxt    = res_bit_r;
    res_found_nxt  = res_found_r;
    res_status_nxt = res_status_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    ram_we         = 1'b0;
    ram_waddr      = wcnt_r;
    ram_wdata      = '0;
    ram_raddr      = wcnt_r;

    case (state_r)
      // Write every word: in-use ones for set all, zeros otherwise.
      S_FILL: begin
        ram_we    = 1'b1;
        ram_wdata = fill_set_r ? word_mask : '0;
        if (wcnt_r == LAST_WORD) begin
          wcnt_nxt  = '0;
          cnt_nxt   = fill_set_r ? n_r : '0;
          state_nxt = report_r ? S_DONE : S_IDLE;
        end else begin
          wcnt_nxt = wcnt_r + WADDR_W'(1);
        end
      end

      // Take a request and start its RAM access.
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt        = in_cmd;
          res_bit_nxt    = 1'b0;
          res_found_nxt  = '0;
          res_status_nxt = bam_pkg::STAT_OK;
          wcnt_nxt       = '0;
          case (in_cmd)
            bam_pkg::CMD_MARK, bam_pkg::CMD_CLEAR, bam_pkg::CMD_FLIP,
            bam_pkg::CMD_TEST: begin
              if (in_range) begin
                ram_raddr = WADDR_W'(idx_ext >> SH);
                waddr_nxt = WADDR_W'(idx_ext >> SH);
                pos_nxt   = idx_ext[SH-1:0];
                state_nxt = S_MOD;
              end else begin
                res_status_nxt = bam_pkg::STAT_RANGE;
                state_nxt      = S_DONE;
              end
            end
            bam_pkg::CMD_FIND_SET, bam_pkg::CMD_FIND_CLEAR: begin
              ram_raddr = '0;
              state_nxt = S_SCAN;
            end
            bam_pkg::CMD_SET_ALL: begin
              fill_set_nxt = 1'b1;
              report_nxt   = 1'b1;
              state_nxt    = S_FILL;
            end
            default: begin
              fill_set_nxt = 1'b0;
              report_nxt   = 1'b1;
              state_nxt    = S_FILL;
            end
          endcase
        end
      end

      // Read data has arrived: change the bit and write the word back.
      S_MOD: begin
        ram_we      = 1'b1;
        ram_waddr   = waddr_r;
        ram_wdata   = mod_word;
        res_bit_nxt = old_bit;
        if (new_bit && !old_bit) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end else if (old_bit && !new_bit) begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
        state_nxt = S_DONE;
      end

      // One word per cycle: look at word wcnt_r while the next one is read; flip the found bit.
      S_SCAN: begin
        ram_raddr = wcnt_r + WADDR_W'(1);
        if (hit) begin
          ram_we        = 1'b1;
          ram_waddr     = wcnt_r;
          ram_wdata     = ram_rdata ^ ({{(WORD_BITS-1){1'b0}}, 1'b1} << hit_pos);
          cnt_nxt       = (cmd_r == bam_pkg::CMD_FIND_SET) ? cnt_r + CNT_W'(1)
                                                           : cnt_r - CNT_W'(1);
          res_found_nxt = bam_pkg::IDX_W'((32'(wcnt_r) << SH) | 32'(hit_pos));
          state_nxt     = S_DONE;
        end else if (wcnt_r == LAST_WORD) begin
          res_status_nxt = bam_pkg::STAT_NONE;
          state_nxt      = S_DONE;
        end else begin
          wcnt_nxt = wcnt_r + WADDR_W'(1);
        end
      end

      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt = 32'({(cnt_r == n_r),
                              (cnt_r != '0),
                              bam_pkg::COUNT_W'(cnt_r),
                              res_status_r,
                              res_found_r,
                              res_bit_r});
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // A write of bits_in_use restarts the clearing pass.
    if (cfg_wr) begin
      n_nxt        = cfg_sat;
      cnt_nxt      = '0;
      wcnt_nxt     = '0;
      fill_set_nxt = 1'b0;
      report_nxt   = 1'b0;
      state_nxt    = S_FILL;
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    pos_r        <= pos_nxt;
    waddr_r      <= waddr_nxt;
    res_bit_r    <= res_bit_nxt;
    res_found_r  <= res_found_nxt;
    res_status_r <= res_status_nxt;
    out_data_r   <= out_data_nxt;
    if (!rst_n) begin
      state_r     <= S_FILL;
      n_r         <= CNT_W'(MAX_BITS);
      cnt_r       <= '0;
      wcnt_r      <= '0;
      fill_set_r  <= 1'b0;
      report_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      cnt_r       <= cnt_nxt;
      wcnt_r      <= wcnt_nxt;
      fill_set_r  <= fill_set_nxt;
      report_r    <= report_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

@@ src/bam_checker.sv @@
// Port-level checker of the bitmap allocator and its bind to the top level.
// It depends on bam_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module bam_port_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic        cfg_psel,
  input wire logic        cfg_penable,
  input wire logic        cfg_pwrite,
  input wire logic [2:0]  cfg_paddr
);

  logic out_stall;
  logic in_take;
  logic cfg_write_hit;
  logic range_result;

  assign out_stall     = out_tvalid && !out_tready;
  assign in_take       = in_tvalid && in_tready;
  assign cfg_write_hit = cfg_psel && cfg_penable && cfg_pwrite &&
                         (cfg_paddr[2] == bam_pkg::REG_BITS_IN_USE);
  assign range_result  = out_tvalid && (out_tdata[12:11] == bam_pkg::STAT_RANGE);

  // A stalled result holds.
  `BAM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_tvalid && $stable(out_tdata))

  // Requests are handled one at a time.
  `BAM_ASSERT_NEXT(a_one_request, clk, rst_n, in_take, !in_tready)

  // A write of bits_in_use starts the clearing pass, which blocks requests.
  `BAM_ASSERT_NEXT(a_cfg_clears, clk, rst_n, cfg_write_hit, !in_tready)

  // An out-of-range result reports no bit value and no found index.
  `BAM_ASSERT_SAME(a_range_zero, clk, rst_n, range_result, out_tdata[10:0] == 11'd0)

endmodule

bind bitmap_allocator_unit bam_port_checker u_bam_checker (.*);

`default_nettype wire

@@ bench/bam_checker.sv @@
// Scoreboard for the bitmap allocator: it snoops the request, result and register channels,
// keeps its own copy of the bit map and checks every result in order.
// It depends on bam_pkg for the command and status codes and the field widths.
`timescale 1ns / 1ps

module bam_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          mismatches,
  output int          pending,
  output int          checked
);

  // Result fields from the top bit down, so that a cast of out_tdata[25:0] unpacks them.
  typedef struct packed {
    logic                          all_set;
    logic                          any_set;
    logic [bam_pkg::COUNT_W-1:0]   set_count;
    bam_pkg::status_t              status;
    logic [bam_pkg::IDX_W-1:0]     found_index;
    logic                          bit_value;
  } alloc_result_t;

  logic [bam_pkg::MAX_BITS_DEF-1:0] bit_map;
  int unsigned                      map_count;
  int unsigned                      map_size;
  alloc_result_t                    result_q[$];
  int                               n_bad;
  int                               n_checked;

  // Update one bit and keep the set-bit count in step.
  function automatic void store_bit(input logic [bam_pkg::IDX_W-1:0] pos, input logic value);
    if (bit_map[pos] != value) begin
      bit_map[pos] = value;
      if (value) map_count++;
      else map_count--;
    end
  endfunction

  // Apply one request to the shadow map and return the result it must produce.
  function automatic alloc_result_t apply_request(input bam_pkg::cmd_t cmd,
                                                  input logic [bam_pkg::IDX_W-1:0] idx);
    alloc_result_t r;
    logic          want;
    int unsigned   i;
    r = '0;
    case (cmd)
      bam_pkg::CMD_MARK, bam_pkg::CMD_CLEAR, bam_pkg::CMD_FLIP, bam_pkg::CMD_TEST: begin
        if (idx >= map_size) begin
          r.status = bam_pkg::STAT_RANGE;
        end else begin
          r.bit_value = bit_map[idx];
          case (cmd)
            bam_pkg::CMD_MARK:  store_bit(idx, 1'b1);
            bam_pkg::CMD_CLEAR: store_bit(idx, 1'b0);
            bam_pkg::CMD_FLIP:  store_bit(idx, ~r.bit_value);
            default: ;
          endcase
        end
      end
      bam_pkg::CMD_FIND_SET, bam_pkg::CMD_FIND_CLEAR: begin
        // Find-set looks for the lowest clear bit, find-clear for the lowest set bit.
        want = (cmd == bam_pkg::CMD_FIND_CLEAR);
        r.status = bam_pkg::STAT_NONE;
        for (i = 0; i < map_size && r.status == bam_pkg::STAT_NONE; i++) begin
          if (bit_map[i[bam_pkg::IDX_W-1:0]] == want) begin
            store_bit(i[bam_pkg::IDX_W-1:0], ~want);
            r.found_index = i[bam_pkg::IDX_W-1:0];
            r.status = bam_pkg::STAT_OK;
          end
        end
      end
      bam_pkg::CMD_SET_ALL: begin
        for (i = 0; i < map_size; i++) store_bit(i[bam_pkg::IDX_W-1:0], 1'b1);
      end
      default: begin
        bit_map = '0;
        map_count = 0;
      end
    endcase
    r.set_count = map_count[bam_pkg::COUNT_W-1:0];
    r.any_set = (map_count != 0);
    r.all_set = (map_count == map_size);
    return r;
  endfunction

  always @(posedge clk) begin
    alloc_result_t got;
    alloc_result_t want_r;
    int unsigned   value;
    if (!rst_n) begin
      bit_map = '0;
      map_count = 0;
      map_size = bam_pkg::MAX_BITS_DEF;
      result_q.delete();
    end else begin
      // A write of bits_in_use saturates it and empties the store.
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr[2] == bam_pkg::REG_BITS_IN_USE) begin
        value = cfg_pwdata & 32'h7FF;
        map_size = (value > bam_pkg::MAX_BITS_DEF) ? bam_pkg::MAX_BITS_DEF : value;
        bit_map = '0;
        map_count = 0;
      end

      // Check a result transaction against the oldest expectation.
      if (out_tvalid && out_tready) begin
        got = alloc_result_t'(out_tdata[25:0]);
        if (result_q.size() == 0) begin
          n_bad++;
          if (n_bad <= 10)
            $display("[%0t] result %h arrived with nothing outstanding",
                     $realtime, out_tdata);
        end else begin
          want_r = result_q.pop_front();
          n_checked++;
          if (got !== want_r || out_tdata[31:26] !== 6'b0) begin
            n_bad++;
            if (n_bad <= 10) begin
              $display("[%0t] result mismatch: bit_value exp %0d got %0d", $realtime,
                       want_r.bit_value, got.bit_value);
              $display("  found_index exp %0d got %0d, status exp %0d got %0d",
                       want_r.found_index, got.found_index, want_r.status, got.status);
              $display("  set_count exp %0d got %0d, any exp %0d got %0d, all exp %0d got %0d",
                       want_r.set_count, got.set_count, want_r.any_set, got.any_set,
                       want_r.all_set, got.all_set);
            end
          end
        end
      end

      // Every accepted request produces exactly one result.
      if (in_tvalid && in_tready)
        result_q.push_back(apply_request(bam_pkg::cmd_t'(in_tdata[2:0]), in_tdata[12:3]));
    end
    mismatches <= n_bad;
    pending <= result_q.size();
    checked <= n_checked;
  end

endmodule

@@ bench/tb_bitmap_allocator_unit.sv @@
// Testbench top for bitmap_allocator_unit: clock, reset, request and register stimulus,
// result back-pressure, watchdog and verdict. It depends on bam_pkg and bam_checker.
`timescale 1ns / 1ps

module tb_bitmap_allocator_unit;

  localparam int LONG_HOLD  = 300;
  localparam int IDLE_LIMIT = 4000;
  localparam int PHASE_ITEMS = 170;

  // Byte addresses of the register file; index 1 is not mapped.
  localparam logic [2:0] ADDR_BITS_IN_USE = {bam_pkg::REG_BITS_IN_USE, 2'b00};
  localparam logic [2:0] ADDR_UNMAPPED    = 3'd4;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;     // cmd [2:0], bit_index [12:3], zero [15:13]
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;    // bit_value [0], found_index [10:1], status [12:11],
                             // set_count [23:13], any_set [24], all_set [25]
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int mismatches;
  int pending;
  int checked;
  int map_span;        // bits_in_use as the block should hold it
  int requests_sent;
  int reg_writes;
  int hold_req;
  int hold_done;
  bit no_idle;
  int idle_cycles;

  always #4 clk = ~clk;

  bitmap_allocator_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  bam_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_pready(cfg_pready),
    .mismatches(mismatches), .pending(pending), .checked(checked)
  );

  // Offer one request after a random gap (none in the no-idle stretch) and hold it until the transaction completes.
  task automatic send_request(input bam_pkg::cmd_t cmd, input logic [9:0] idx);
    int gap;
    gap = no_idle ? 0 : $urandom_range(9);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata <= {3'b000, idx, cmd};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    requests_sent++;
  endtask

  // Random request; indexes mostly fall inside the managed range.
  task automatic send_random();
    int            roll;
    bam_pkg::cmd_t cmd;
    logic [9:0]    idx;
    roll = $urandom_range(99);
    if (roll < 28)      cmd = bam_pkg::CMD_FIND_SET;
    else if (roll < 42) cmd = bam_pkg::CMD_FIND_CLEAR;
    else if (roll < 54) cmd = bam_pkg::CMD_MARK;
    else if (roll < 66) cmd = bam_pkg::CMD_CLEAR;
    else if (roll < 77) cmd = bam_pkg::CMD_FLIP;
    else if (roll < 91) cmd = bam_pkg::CMD_TEST;
    else if (roll < 96) cmd = bam_pkg::CMD_SET_ALL;
    else                cmd = bam_pkg::CMD_CLEAR_ALL;
    if (map_span > 0 && $urandom_range(9) < 8) idx = 10'($urandom_range(map_span - 1));
    else idx = 10'($urandom_range(1023));
    send_request(cmd, idx);
  endtask

  // Stop offering and wait until every result has been delivered.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Two-phase register write; the block is idle whenever this is called.
  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    reg_writes++;
    if (addr == ADDR_BITS_IN_USE)
      map_span = ((data & 32'h7FF) > 1024) ? 1024 : (data & 32'h7FF);
  endtask

  // Result side: random stalls, one long hold-off on request, none in the no-idle stretch.
  initial begin : result_sink
    int rx_wait;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req != hold_done) begin
        rx_wait = LONG_HOLD;
        hold_done = hold_req;
      end else begin
        rx_wait = no_idle ? 0 : $urandom_range(9);
      end
      if (rx_wait > 0) begin
        out_tready <= 1'b0;
        repeat (rx_wait) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles, %0d results outstanding",
               idle_cycles, pending);
      $display("FAIL bitmap_allocator_unit");
      $finish;
    end
  end

  initial begin : stimulus
    int phase_span[9];
    int p;
    int k;
    int failures;
    phase_span = '{1024, 33, 1, 32, 100, 0, 1023, 7, 1024};
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    map_span = 1024;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty map, single-bit operations at both ends, full map.
    send_request(bam_pkg::CMD_TEST, 10'd0);
    send_request(bam_pkg::CMD_FIND_CLEAR, 10'd0);
    send_request(bam_pkg::CMD_FIND_SET, 10'd0);
    send_request(bam_pkg::CMD_MARK, 10'd1023);
    send_request(bam_pkg::CMD_TEST, 10'd1023);
    send_request(bam_pkg::CMD_FLIP, 10'd1023);
    send_request(bam_pkg::CMD_FLIP, 10'd5);
    send_request(bam_pkg::CMD_CLEAR, 10'd5);
    send_request(bam_pkg::CMD_CLEAR, 10'd5);
    send_request(bam_pkg::CMD_SET_ALL, 10'd0);
    send_request(bam_pkg::CMD_FIND_SET, 10'd0);
    send_request(bam_pkg::CMD_FIND_CLEAR, 10'd1023);
    send_request(bam_pkg::CMD_CLEAR_ALL, 10'd0);
    drain();

    // Zero positions in use: everything is out of range and the map counts as full.
    cfg_write(ADDR_BITS_IN_USE, 32'd0);
    send_request(bam_pkg::CMD_TEST, 10'd0);
    send_request(bam_pkg::CMD_FIND_SET, 10'd0);
    send_request(bam_pkg::CMD_SET_ALL, 10'd0);
    drain();

    // Three positions: range edge, allocation until none is left.
    cfg_write(ADDR_BITS_IN_USE, 32'd3);
    send_request(bam_pkg::CMD_MARK, 10'd3);
    send_request(bam_pkg::CMD_MARK, 10'd2);
    send_request(bam_pkg::CMD_FIND_SET, 10'd0);
    send_request(bam_pkg::CMD_FIND_SET, 10'd0);
    send_request(bam_pkg::CMD_FIND_SET, 10'd0);
    send_request(bam_pkg::CMD_FIND_CLEAR, 10'd0);
    drain();

    // A write to an unmapped register must leave the map alone.
    cfg_write(ADDR_UNMAPPED, 32'd5);
    send_request(bam_pkg::CMD_TEST, 10'd1);
    drain();

    // Bits above the register width are dropped; oversized values saturate.
    cfg_write(ADDR_BITS_IN_USE, 32'hFFFF_F805);
    send_request(bam_pkg::CMD_TEST, 10'd4);
    send_request(bam_pkg::CMD_TEST, 10'd5);
    drain();
    cfg_write(ADDR_BITS_IN_USE, 32'h0000_07FF);
    send_request(bam_pkg::CMD_SET_ALL, 10'd1023);
    drain();

    // Random phases over a range of map sizes.
    for (p = 0; p < 9; p++) begin
      cfg_write(ADDR_BITS_IN_USE, phase_span[p]);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 1 && k == 40) hold_req++;
        if (p == 2 && k == 80) drain();
        no_idle = (p == 4 && k < 80);
        send_random();
      end
      drain();
    end

    repeat (40) @(posedge clk);
    failures = mismatches + pending;
    $display("Ran %0d requests with %0d results checked and %0d register writes,",
             requests_sent, checked, reg_writes);
    $display("covering map sizes 0 to 1024, saturating and unmapped writes and a long stall.");
    if (failures == 0)
      $display("PASS bitmap_allocator_unit");
    else
      $display("FAIL bitmap_allocator_unit");
    $finish;
  end

endmodule
